### rtl/fnvbch_pkg.sv
// Package for the FNV-1a block chain hash core.
// Holds the hash constants, the sequencer state type and the byte mix function.
// No dependencies.
package fnvbch_pkg;

  localparam logic [63:0] FNV_BASIS        = 64'hCBF2_9CE4_8422_2325;
  localparam int          PRIME_SHIFT      = 40;
  localparam logic [8:0]  PRIME_LO         = 9'h1B3;
  localparam int          MAX_BLOCK_TOKENS = 256;
  localparam int          CNT_W            = $clog2(MAX_BLOCK_TOKENS + 1);
  localparam logic [CNT_W-1:0] MAX_TOKENS  = CNT_W'(MAX_BLOCK_TOKENS);
  localparam logic [7:0]  BYTE_MASK        = 8'hFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PARENT,
    S_LEN,
    S_TOKEN,
    S_DONE
  } seq_state_t;

  // prime = 2^40 + 0x1b3, so the product is a shift plus a narrow constant multiply
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b & BYTE_MASK};
    return (x << PRIME_SHIFT) + (x * {55'd0, PRIME_LO});
  endfunction

endpackage

### rtl/fnvbch_mix.sv
// Shared FNV-1a byte mix unit: XOR one byte into the hash, multiply by the prime.
// Depends on fnvbch_pkg.
module fnvbch_mix (
  input  logic [63:0] h_in,
  input  logic [7:0]  byte_in,
  output logic [63:0] h_out
);
  import fnvbch_pkg::*;

  assign h_out = fnv_mix(h_in, byte_in);

endmodule

### rtl/fnv1a_block_chain_hash_core.sv
// FNV-1a 64-bit block chain hash core: one byte is mixed per clock through a single
// shared mix unit, unless idle or waiting on the output. A token item mixes its four
// bytes; a header item mixes a flag byte, eight parent hash bytes when one is chained in,
// then eight length bytes, and a block with tokens then mixes its first token. in_ready
// is high only while the sequencer is idle. block_hash sits in an output register; if
// still held when the next result finishes, the sequencer waits until it is taken.
// Depends on fnvbch_pkg and fnvbch_mix.
module fnv1a_block_chain_hash_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               block_start,
  input  logic               has_parent,
  input  logic [63:0]        parent_digest,
  input  logic [8:0]         block_length,
  input  logic signed [31:0] token_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        block_hash
);
  import fnvbch_pkg::*;

  seq_state_t       state, state_next;
  logic [2:0]       cnt;
  logic [63:0]      h;
  logic [CNT_W-1:0] tokens_left;
  logic [63:0]      parent_q;
  logic [31:0]      tok_q;

  logic             in_fire, out_free;
  logic [63:0]      mix_h_in, mix_out, len64;
  logic [7:0]       mix_byte;
  logic             h_load, emit_now, emit_held;
  logic [CNT_W-1:0] len_sat;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign len_sat  = (block_length > MAX_TOKENS) ? MAX_TOKENS : block_length;
  assign len64    = {{(64-CNT_W){1'b0}}, tokens_left};

  fnvbch_mix u_mix (
    .h_in    (mix_h_in),
    .byte_in (mix_byte),
    .h_out   (mix_out)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (block_start) begin
            state_next = has_parent ? S_PARENT : S_LEN;
          end else if (tokens_left != '0) begin
            state_next = S_TOKEN;
          end
        end
      end
      S_PARENT: begin
        if (cnt == 3'd7) state_next = S_LEN;
      end
      S_LEN: begin
        if (cnt == 3'd7) begin
          if (tokens_left != '0) state_next = S_TOKEN;
          else                   state_next = out_free ? S_IDLE : S_DONE;
        end
      end
      S_TOKEN: begin
        if (cnt == 3'd3) begin
          if (tokens_left == CNT_W'(1)) state_next = out_free ? S_IDLE : S_DONE;
          else                          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mix_h_in  = h;
    mix_byte  = '0;
    h_load    = 1'b0;
    emit_now  = 1'b0;
    emit_held = 1'b0;
    case (state)
      S_IDLE: begin
        mix_h_in = block_start ? FNV_BASIS : h;
        mix_byte = block_start ? {7'd0, has_parent} : token_word[7:0];
        h_load   = in_fire && (block_start || tokens_left != '0);
      end
      S_PARENT: begin
        mix_byte = parent_q[{cnt, 3'b000} +: 8];
        h_load   = 1'b1;
      end
      S_LEN: begin
        mix_byte = len64[{cnt, 3'b000} +: 8];
        h_load   = 1'b1;
        emit_now = (cnt == 3'd7) && (tokens_left == '0) && out_free;
      end
      S_TOKEN: begin
        mix_byte = tok_q[{cnt[1:0], 3'b000} +: 8];
        h_load   = 1'b1;
        emit_now = (cnt == 3'd3) && (tokens_left == CNT_W'(1)) && out_free;
      end
      S_DONE: begin
        emit_held = out_free;
      end
      default: begin
        mix_byte = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      h           <= FNV_BASIS;
      tokens_left <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) cnt <= block_start ? 3'd0 : 3'd1;
      else if (state != S_IDLE && state != S_DONE) cnt <= cnt + 3'd1;
      if (h_load) h <= mix_out;
      if (in_fire && block_start) tokens_left <= len_sat;
      else if (state == S_TOKEN && cnt == 3'd3) tokens_left <= tokens_left - CNT_W'(1);
      if (emit_now || emit_held) out_valid <= 1'b1;
      else if (out_ready)        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      parent_q <= parent_digest;
      tok_q    <= token_word;
    end
    if (emit_now)       block_hash <= mix_out;
    else if (emit_held) block_hash <= h;
  end

  a_tokens_bound: assert property (@(posedge clk) disable iff (rst)
    tokens_left <= MAX_TOKENS)
    else $error("tokens_left above block limit");

  a_done_holds_output: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> out_valid)
    else $error("waiting to emit with output register empty");

  a_token_needs_count: assert property (@(posedge clk) disable iff (rst)
    state == S_TOKEN |-> tokens_left != '0)
    else $error("token mix with no tokens left");

  a_start_goes_header: assert property (@(posedge clk) disable iff (rst)
    in_fire && block_start |=> state == S_PARENT || state == S_LEN)
    else $error("header transfer did not enter header mix");

  a_token_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == S_TOKEN |-> cnt <= 3'd3)
    else $error("token byte counter out of range");

endmodule
